// File: rtl/core/fpm_pkg.sv
// Shared constants and types for the first pattern match finder.
package fpm_pkg;

	localparam int MAX_PATTERN   = 8;
	localparam int POSITION_BITS = 16;
	localparam int BYTE_W        = 8;
	localparam int PAT_W         = BYTE_W * MAX_PATTERN;
	localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
	localparam int SEL_W         = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CFG_W         = 64;
	localparam int CFG_IDX_W     = 2;
	localparam int LEN_REG_W     = 4;
	localparam int OUT_POS_W     = 16;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(1);

	// Per-cell control from the top level
	typedef struct packed {
		logic shift_en;  // a new byte enters the chain this cycle
		logic used;      // this cell's offset lies inside the active pattern
	} cell_ctl_t;

endpackage

// File: rtl/core/fpm_cell.sv
// One window cell: holds one earlier text byte and compares it with its pattern byte.
module fpm_cell
	import fpm_pkg::*;
(
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [BYTE_W-1:0] byte_in,
	input  logic [BYTE_W-1:0] want,
	output logic [BYTE_W-1:0] byte_q,
	output logic              ok
);

	// window byte, handed on from the neighbor on each shift
	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			byte_q <= byte_in;
		end
	end

	// offsets beyond the pattern always agree
	assign ok = !ctl.used || (byte_q == want);

endmodule

// File: rtl/core/first_pattern_match_finder_unit.sv
// Top level of the first pattern match finder: cell chain, position counter, result register.
// A result is in the output register from the cycle after the byte that causes it is accepted.
// Throughput: one text byte per cycle while in_ready is high; the whole window is compared
//   by the cell row in the cycle a byte is accepted; the result register drains in parallel.
// Input stalls only while a result waits in the output register and out_ready is low.
// Reset (arst_n low): pattern cleared to zero, length set to one, position counter and
//   match flag cleared, output register empty; window bytes are not reset.
module first_pattern_match_finder_unit
	import fpm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    text_byte,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 found,
	output logic [OUT_POS_W-1:0] match_position
);

	logic [PAT_W-1:0]         pattern_q;
	logic [LEN_REG_W-1:0]     length_q;
	logic [POSITION_BITS-1:0] bytes_seen_q;
	logic                     reported_q;
	logic [LEN_W-1:0]         len_act;
	logic                     in_fire;
	logic                     shift_en;
	logic                     counted;
	logic [POSITION_BITS-1:0] seen_next;
	logic [POSITION_BITS-1:0] start_pos;
	logic [MAX_PATTERN-1:0]   lane_ok;
	logic [BYTE_W-1:0]        chain [MAX_PATTERN];
	logic                     hit;
	logic                     load;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= LEN_REG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_BYTES:  pattern_q <= cfg_data[PAT_W-1:0];
				REG_PATTERN_LENGTH: length_q  <= cfg_data[LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// active length: zero acts as one, oversize clamps
	always_comb begin
		if (length_q == '0) begin
			len_act = LEN_W'(1);
		end else if (32'(length_q) > MAX_PATTERN) begin
			len_act = LEN_W'(MAX_PATTERN);
		end else begin
			len_act = LEN_W'(length_q);
		end
	end

	assign in_ready = !out_valid || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign shift_en = in_fire && !reported_q;

	// offset zero is the incoming byte, compared against the last pattern byte
	assign chain[0]   = text_byte;
	assign lane_ok[0] = (text_byte == pattern_q[BYTE_W * SEL_W'(len_act - LEN_W'(1)) +: BYTE_W]);

	// row of cells, cell j holds the byte j steps back
	for (genvar j = 1; j < MAX_PATTERN; j++) begin : g_cell
		cell_ctl_t        ctl;
		logic [SEL_W-1:0] sel;

		assign ctl.shift_en = shift_en;
		assign ctl.used     = (len_act > LEN_W'(j));
		assign sel          = SEL_W'(len_act - LEN_W'(j + 1));

		fpm_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.byte_in (chain[j-1]),
			.want    (pattern_q[BYTE_W * sel +: BYTE_W]),
			.byte_q  (chain[j]),
			.ok      (lane_ok[j])
		);
	end

	// position counter, saturating at all ones
	assign counted   = (bytes_seen_q != '1);
	assign seen_next = bytes_seen_q + POSITION_BITS'(1);
	assign start_pos = seen_next - POSITION_BITS'(len_act) + POSITION_BITS'(1);
	assign hit       = counted && (seen_next >= POSITION_BITS'(len_act)) && (&lane_ok);
	assign load      = shift_en && (hit || last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			reported_q   <= 1'b0;
		end else if (in_fire) begin
			if (last_byte) begin
				bytes_seen_q <= '0;
				reported_q   <= 1'b0;
			end else if (!reported_q) begin
				if (counted) begin
					bytes_seen_q <= seen_next;
				end
				if (hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			found          <= hit;
			match_position <= hit ? OUT_POS_W'(start_pos) : '0;
		end
	end

	// a reported match leaves a found word waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(reported_q) |-> out_valid && found)
		else $error("match flag set without a found word");

	// not-found words carry position zero, found words a nonzero start
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (found ? (match_position != '0) : (match_position == '0)))
		else $error("position inconsistent with found flag");

	// the last byte restarts the search
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last_byte |=> bytes_seen_q == '0 && !reported_q)
		else $error("search not restarted after last byte");

	// a waiting word that is not taken blocks input
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result register is full");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the first pattern match finder: directed and random texts.
`timescale 1ns / 100ps

module testbench;
	import fpm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int PHASE_COUNT    = 12;
	localparam int PHASE_WORDS    = 145;

	// Indexes that decode to no register; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	typedef struct packed {
		logic                 found;
		logic [OUT_POS_W-1:0] pos;
	} match_result_t;

	// Tracks the search state and queues the match result of every text
	class match_scoreboard;
		logic [PAT_W-1:0]         pat_bytes;
		logic [LEN_REG_W-1:0]     pat_len;
		logic [BYTE_W-1:0]        recent [MAX_PATTERN-1];
		logic [POSITION_BITS-1:0] seen;
		bit                       reported;
		match_result_t            expected_q [$];
		int                       errors;

		function new();
			errors = 0;
			reset_all();
		endfunction

		function void restart_text();
			foreach (recent[i])
				recent[i] = '0;
			seen = '0;
			reported = 1'b0;
		endfunction

		function void reset_all();
			pat_bytes = '0;
			pat_len = LEN_REG_W'(1);
			restart_text();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_PATTERN_BYTES)
				pat_bytes = data[PAT_W-1:0];
			else if (idx == REG_PATTERN_LENGTH)
				pat_len = data[LEN_REG_W-1:0];
		endfunction

		// Zero acts as one, anything above the maximum as the maximum
		function int active_len();
			if (pat_len == 0)
				return 1;
			if (pat_len > MAX_PATTERN)
				return MAX_PATTERN;
			return int'(pat_len);
		endfunction

		// Pattern char k lines up with the byte len-1-k steps back
		function bit window_hit(logic [BYTE_W-1:0] b, int len);
			int j;
			logic [BYTE_W-1:0] got;
			for (int k = 0; k < len; k++) begin
				j = len - 1 - k;
				got = (j == 0) ? b : recent[j-1];
				if (got != pat_bytes[8*k +: 8])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_word(logic [BYTE_W-1:0] b, logic l);
			bit counted;
			int len;
			match_result_t r;
			if (!reported) begin
				counted = (seen != {POSITION_BITS{1'b1}});
				len = active_len();
				if (counted)
					seen = seen + 1'b1;
				if (counted && int'(seen) >= len && window_hit(b, len)) begin
					r.found = 1'b1;
					r.pos = OUT_POS_W'(int'(seen) - len + 1);
					expected_q.push_back(r);
					reported = 1'b1;
				end else if (l) begin
					r.found = 1'b0;
					r.pos = '0;
					expected_q.push_back(r);
				end
				for (int i = MAX_PATTERN - 2; i > 0; i--)
					recent[i] = recent[i-1];
				recent[0] = b;
			end
			if (l)
				restart_text();
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic f, logic [OUT_POS_W-1:0] p);
			match_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result found=%0d pos=%0d", f, p));
			end else begin
				want = expected_q.pop_front();
				if (f !== want.found)
					report($sformatf("found %0d, want %0d", f, want.found));
				if (p !== want.pos)
					report($sformatf("match_position %0d, want %0d", p, want.pos));
			end
		endtask

		task finish_check();
			if (expected_q.size() != 0)
				report($sformatf("%0d results never arrived", expected_q.size()));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    text_byte = '0;
	logic                 last_byte = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 found;
	logic [OUT_POS_W-1:0] match_position;

	match_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	first_pattern_match_finder_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.text_byte      (text_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found          (found),
		.match_position (match_position)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Results are checked before the word of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(found, match_position);
			if (in_valid && in_ready)
				sb.note_word(text_byte, last_byte);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void set_idling(int mode);
		case (mode % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 83;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 83;
			end
			default: begin
				send_idle_pct = 31;
				recv_stall_pct = 31;
			end
		endcase
	endfunction

	// Offers one word and returns at the falling edge after its acceptance
	task automatic send_word(input logic [BYTE_W-1:0] b, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		last_byte <= l;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Block is idle: no result pending and the last word has left the pipe
	task automatic wait_idle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.expected_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Upper data bits are random; only the low nibble is the length
	task automatic cfg_length(input logic [LEN_REG_W-1:0] len);
		logic [CFG_W-1:0] data;
		data = {$urandom, $urandom};
		data[LEN_REG_W-1:0] = len;
		cfg_write(REG_PATTERN_LENGTH, data);
	endtask

	// Mostly characters of the active pattern, sometimes any value
	function automatic logic [BYTE_W-1:0] pick_char(int plen);
		if ($urandom_range(3) == 0)
			return BYTE_W'($urandom_range(255));
		return sb.pat_bytes[8*$urandom_range(plen-1) +: 8];
	endfunction

	// One whole text: random content, sometimes with a full or partial pattern planted in it
	task automatic send_random_text(inout int sent);
		logic [BYTE_W-1:0] buffer [$];
		int len, plen, spot, kind, cut;
		plen = sb.active_len();
		len = ($urandom_range(19) == 0) ? 1 : $urandom_range(1, 40);
		for (int i = 0; i < len; i++)
			buffer.push_back(pick_char(plen));
		kind = $urandom_range(9);
		spot = $urandom_range(len);
		cut = 0;
		if (kind < 5)
			cut = plen;
		else if (kind < 7 && plen > 1)
			cut = $urandom_range(1, plen - 1);
		for (int k = 0; k < cut; k++)
			buffer.insert(spot + k, sb.pat_bytes[8*k +: 8]);
		foreach (buffer[i])
			send_word(buffer[i], i == buffer.size() - 1);
		sent += buffer.size();
	endtask

	function automatic logic [PAT_W-1:0] make_pattern(int phase);
		logic [PAT_W-1:0] pat;
		logic [BYTE_W-1:0] alpha [3];
		case (phase % 3)
			0: begin
				foreach (alpha[i])
					alpha[i] = BYTE_W'($urandom_range(255));
				for (int k = 0; k < MAX_PATTERN; k++)
					pat[8*k +: 8] = alpha[$urandom_range(2)];
			end
			1: pat = {$urandom, $urandom};
			default: pat = (phase % 2 == 0) ? '1 : '0;
		endcase
		return pat;
	endfunction

	initial begin
		int sent;
		logic [LEN_REG_W-1:0] len;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset pattern is a single zero byte; the rest of the text is absorbed
		set_idling(0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);

		// Length above the maximum acts as the maximum; match on the last byte
		wait_idle();
		cfg_write(REG_PATTERN_BYTES, 64'h1122_3344_5566_7788);
		cfg_length(4'd15);
		for (int k = 0; k < MAX_PATTERN; k++)
			send_word(sb.pat_bytes[8*k +: 8], k == MAX_PATTERN - 1);

		// Length zero acts as one, upper pattern bytes ignored
		wait_idle();
		cfg_length(4'd0);
		send_word(8'hFF, 1'b0);
		send_word(8'h88, 1'b0);
		send_word(8'h00, 1'b1);

		// Texts shorter than the pattern; nothing carries over between texts
		wait_idle();
		cfg_length(4'd8);
		send_word(8'h00, 1'b0);
		send_word(8'h88, 1'b1);
		for (int k = 1; k < MAX_PATTERN; k++)
			send_word(sb.pat_bytes[8*k +: 8], k == MAX_PATTERN - 1);

		// Pattern changed mid-text, new pattern meets the bytes held in the window
		send_word(8'h88, 1'b0);
		send_word(8'h77, 1'b0);
		wait_idle();
		cfg_write(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_4277);
		cfg_length(4'd2);
		send_word(8'h42, 1'b1);

		// Random phases over several settings and idling patterns
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			wait_idle();
			set_idling(phase);
			case (phase)
				0: len = 4'd1;
				1: len = 4'd8;
				2: len = 4'd0;
				3: len = 4'd15;
				default: len = LEN_REG_W'($urandom_range(15));
			endcase
			cfg_write(($urandom_range(1) == 0) ? REG_SPARE_A : REG_SPARE_B,
				{$urandom, $urandom});
			cfg_write(REG_PATTERN_BYTES, make_pattern(phase));
			cfg_length(len);
			sent = 0;
			while (sent < PHASE_WORDS)
				send_random_text(sent);
			// leave some texts open across the next register write
			if ($urandom_range(1) == 0) begin
				repeat ($urandom_range(1, 6))
					send_word(pick_char(sb.active_len()), 1'b0);
			end
		end

		wait_idle();
		sb.finish_check();
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
